// ===== hw/rtl/ffba_pkg.sv =====
// Shared types, codes and constants of the first-fit block allocator.
// No dependencies; every other file but ffba_ram takes names from here by scope.
`timescale 1ns / 1ps

package ffba_pkg;

   localparam int POOL_BLOCKS_DEFAULT = 1024;
   localparam int CNT_W   = 11;   // block_count and realtime_reserve width
   localparam int FSTART_W = 10;  // free_start width
   localparam int START_W = 10;   // base_block width

   localparam logic [CNT_W-1:0] RESERVE_RESET = 11'd64;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   typedef struct packed {
      logic                func;
      logic                realtime_req;
      logic [CNT_W-1:0]    block_count;
      logic [FSTART_W-1:0] free_start;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [START_W-1:0] base_block;
   } rsp_type;

   // Control from the sequencer to the run-length unit.
   typedef struct packed {
      logic clear;
      logic step;
      logic used;
   } run_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_SCAN,
      ST_MARK,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/ffba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ffba_run_unit.sv =====
// Free-run length counter with match against the requested block count.
// Depends on ffba_pkg.
`timescale 1ns / 1ps

module ffba_run_unit (
   input  logic                      clock,
   input  ffba_pkg::run_ctl_type     ctl,
   input  logic [ffba_pkg::CNT_W-1:0] count,
   output logic                      hit
);

   logic [ffba_pkg::CNT_W-1:0] run_ff;
   logic [ffba_pkg::CNT_W-1:0] run_in;
   logic [ffba_pkg::CNT_W:0]   run_inc;

   assign run_inc = {1'b0, run_ff} + 1'b1;
   assign hit     = ctl.step && !ctl.used && (run_inc == {1'b0, count});

   always_comb begin
      run_in = run_ff;
      if (ctl.clear) begin
         run_in = '0;
      end else if (ctl.step) begin
         run_in = ctl.used ? '0 : run_inc[ffba_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
   end

endmodule

// ===== hw/rtl/ffba_ctrl.sv =====
// Sequencer: clearing pass, free sweep, first-fit scan and mark sweep.
// Depends on ffba_pkg; drives the bitmap RAM and the run-length unit.
`timescale 1ns / 1ps

module ffba_ctrl #(
   parameter int POOL_BLOCKS = ffba_pkg::POOL_BLOCKS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  ffba_pkg::req_type           req_data,
   input  logic [ffba_pkg::CNT_W-1:0]  reserve,
   output logic                        wr_en,
   output logic [$clog2(POOL_BLOCKS)-1:0] wr_addr,
   output logic                        wr_data,
   output logic                        rd_en,
   output logic [$clog2(POOL_BLOCKS)-1:0] rd_addr,
   input  logic                        rd_data,
   output ffba_pkg::run_ctl_type       run_ctl,
   output logic [ffba_pkg::CNT_W-1:0]  run_count,
   input  logic                        run_hit,
   output logic                        res_valid,
   input  logic                        res_take,
   output ffba_pkg::rsp_type           res_data
);

   localparam int IDX_W = $clog2(POOL_BLOCKS);
   localparam int PTR_W = $clog2(POOL_BLOCKS + 1);
   localparam int SUM_W = (PTR_W > ffba_pkg::CNT_W + 1) ? PTR_W : ffba_pkg::CNT_W + 1;
   localparam logic [PTR_W-1:0] POOL_PTR = PTR_W'(POOL_BLOCKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_BLOCKS - 1);
   localparam logic [SUM_W-1:0] POOL_SUM = SUM_W'(POOL_BLOCKS);

   ffba_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]    scan_ff, scan_in;
   logic [PTR_W-1:0]    hi_ff, hi_in;
   logic [IDX_W-1:0]    chk_ff, chk_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [ffba_pkg::CNT_W-1:0] left_ff, left_in;
   logic [ffba_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]          status_ff, status_in;
   logic [ffba_pkg::START_W-1:0] start_ff, start_in;

   logic [SUM_W-1:0] free_end;
   logic [SUM_W-1:0] count_sum;
   logic [PTR_W-1:0] res_sat;
   logic [PTR_W-1:0] low_top;
   logic [PTR_W-1:0] run_start;

   assign count_sum = SUM_W'(req_data.block_count);
   assign free_end  = SUM_W'(req_data.free_start) + count_sum;
   assign res_sat   = (SUM_W'(reserve) > POOL_SUM) ? POOL_PTR : PTR_W'(reserve);
   assign low_top   = POOL_PTR - res_sat;
   assign run_start = PTR_W'(chk_ff) + PTR_W'(1) - PTR_W'(cnt_ff);

   assign run_count = cnt_ff;
   assign req_ready = (state_ff == ffba_pkg::ST_IDLE);
   assign res_valid = (state_ff == ffba_pkg::ST_DONE);
   assign res_data  = '{status: status_ff, base_block: start_ff};

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      hi_in     = hi_ff;
      chk_in    = chk_ff;
      pend_in   = pend_ff;
      ptr_in    = ptr_ff;
      left_in   = left_ff;
      cnt_in    = cnt_ff;
      status_in = status_ff;
      start_in  = start_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = IDX_W'(scan_ff);
      run_ctl   = '{clear: 1'b0, step: 1'b0, used: rd_data};

      case (state_ff)
         ffba_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == LAST_IDX) begin
               state_in = ffba_pkg::ST_IDLE;
            end
         end
         ffba_pkg::ST_IDLE: begin
            if (req_valid) begin
               status_in = ffba_pkg::STATUS_OK;
               start_in  = '0;
               cnt_in    = req_data.block_count;
               left_in   = req_data.block_count;
               ptr_in    = IDX_W'(req_data.free_start);
               if (req_data.func == ffba_pkg::FUNC_FREE) begin
                  if (free_end > POOL_SUM) begin
                     status_in = ffba_pkg::STATUS_BAD;
                     state_in  = ffba_pkg::ST_DONE;
                  end else if (req_data.block_count == '0) begin
                     state_in = ffba_pkg::ST_DONE;
                  end else begin
                     state_in = ffba_pkg::ST_FREE;
                  end
               end else if (req_data.block_count == '0 || count_sum > POOL_SUM) begin
                  status_in = ffba_pkg::STATUS_BAD;
                  state_in  = ffba_pkg::ST_DONE;
               end else begin
                  run_ctl.clear = 1'b1;
                  pend_in       = 1'b0;
                  scan_in       = req_data.realtime_req ? low_top : '0;
                  hi_in         = req_data.realtime_req ? POOL_PTR : low_top;
                  state_in      = ffba_pkg::ST_SCAN;
               end
            end
         end
         ffba_pkg::ST_FREE, ffba_pkg::ST_MARK: begin
            wr_en   = 1'b1;
            wr_data = (state_ff == ffba_pkg::ST_MARK);
            ptr_in  = ptr_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == ffba_pkg::CNT_W'(1)) begin
               state_in = ffba_pkg::ST_DONE;
            end
         end
         ffba_pkg::ST_SCAN: begin
            run_ctl.step = pend_ff;
            if (run_hit) begin
               // first fit found: mark it from its start
               ptr_in    = IDX_W'(run_start);
               left_in   = cnt_ff;
               start_in  = ffba_pkg::START_W'(run_start);
               status_in = ffba_pkg::STATUS_OK;
               pend_in   = 1'b0;
               state_in  = ffba_pkg::ST_MARK;
            end else if (scan_ff < hi_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               chk_in  = IDX_W'(scan_ff);
               scan_in = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               status_in = ffba_pkg::STATUS_NO_ROOM;
               start_in  = '0;
               state_in  = ffba_pkg::ST_DONE;
            end else begin
               pend_in = 1'b0;
            end
         end
         ffba_pkg::ST_DONE: begin
            if (res_take) begin
               state_in = ffba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::ST_CLEAR;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
      scan_ff   <= scan_in;
      hi_ff     <= hi_in;
      chk_ff    <= chk_in;
      left_ff   <= left_in;
      cnt_ff    <= cnt_in;
      status_ff <= status_in;
      start_ff  <= start_in;
   end

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// First-fit contiguous block allocator over a POOL_BLOCKS-entry bitmap RAM.
// An allocate scans its region and then marks the run that it found; a free clears its
// blocks; a bad request or a free of zero blocks goes straight to the result.
// At most one bitmap read per scan cycle and one write per mark/free cycle; one item at a time.
// Reset (synchronous, active high) runs a clearing pass that frees every block;
// requests wait for it, configuration writes do not.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
   parameter int POOL_BLOCKS = ffba_pkg::POOL_BLOCKS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ffba_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ffba_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [ffba_pkg::CNT_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(POOL_BLOCKS);

   // Realtime reserve register: number of top blocks kept for realtime requests.
   logic [ffba_pkg::CNT_W-1:0] reserve_ff, reserve_in;

   // Output register: holds a finished result until its transfer, so the
   // sequencer can take the next request meanwhile.
   logic              rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             rd_data;

   ffba_pkg::run_ctl_type      run_ctl;
   logic [ffba_pkg::CNT_W-1:0] run_count;
   logic                       run_hit;

   logic              res_valid;
   logic              res_take;
   ffba_pkg::rsp_type res_data;

   // The output slot is free when empty or being drained this cycle.
   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      reserve_in = csr_wr_en ? csr_wr_data : reserve_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_take) begin
         // load a fresh result into the slot
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         // drop the result once its transfer completes
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserve_ff   <= ffba_pkg::RESERVE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         reserve_ff   <= reserve_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: clearing pass, free sweep, first-fit scan, mark sweep.
   ffba_ctrl #(
      .POOL_BLOCKS (POOL_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .reserve   (reserve_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .run_ctl   (run_ctl),
      .run_count (run_count),
      .run_hit   (run_hit),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data)
   );

   // Run-length counter: one bitmap bit per scan cycle in which a read is pending.
   ffba_run_unit u_run (
      .clock (clock),
      .ctl   (run_ctl),
      .count (run_count),
      .hit   (run_hit)
   );

   // Used/free bitmap, one bit per block.
   ffba_ram #(
      .WIDTH (1),
      .DEPTH (POOL_BLOCKS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
